### hw/rtl/mag_minmax_normalizer_defines.svh
// Assertion macros for the verification file of mag_minmax_normalizer (mmn_checker).
// No dependencies; expects aclk and aresetn in the scope of each use.
`ifndef MAG_MINMAX_NORMALIZER_DEFINES_SVH
`define MAG_MINMAX_NORMALIZER_DEFINES_SVH

// checked only out of reset
`define MMN_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define MMN_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hw/rtl/mmn_pkg.sv
// Package for mag_minmax_normalizer: widths, fixed-point constants, sequencer states
// and the rounding/saturation helper. No dependencies.
`timescale 1ns / 1ps

package mmn_pkg;

    localparam int FRAC_BITS = 14;

    localparam int AXES   = 3;
    localparam int AXIS_W = 2;
    localparam int DATA_W = 16;
    localparam int SPAN_W = DATA_W + 1;
    localparam int REM_W  = SPAN_W + 1;

    // quotient of off * 2^(FRAC_BITS+2) / span, one bit per divider step
    localparam int QEXT_W = FRAC_BITS + 3;
    localparam int CNT_W  = $clog2(QEXT_W + 1);
    localparam int SAT_W  = (QEXT_W + 1 > 17) ? QEXT_W + 1 : 17;

    localparam logic signed [SAT_W-1:0] SAT_ONE = SAT_W'(longint'(1) << FRAC_BITS);
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32767);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-32768);

    localparam int NORM_MAX = (FRAC_BITS > 14) ? 32767 : (1 << FRAC_BITS);
    localparam int NORM_MIN = (FRAC_BITS > 14) ? -32768 : -(1 << FRAC_BITS);

    localparam logic signed [DATA_W-1:0] LO_INIT = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] HI_INIT = 16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIV,
        ST_STEP,
        ST_OUT
    } mmn_state_t;

    // round half up, remove the offset, clamp to 16 signed bits
    function automatic logic signed [DATA_W-1:0] round_sat(input logic [QEXT_W-1:0] qext);
        logic [QEXT_W-1:0]       qr;
        logic signed [SAT_W-1:0] v;
        logic signed [DATA_W-1:0] r;
        qr = (qext + QEXT_W'(1)) >> 1;
        v  = $signed(SAT_W'(qr)) - SAT_ONE;
        priority if (v > SAT_MAX) begin
            r = 16'sh7fff;
        end else if (v < SAT_MIN) begin
            r = 16'sh8000;
        end else begin
            r = $signed(v[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

### hw/rtl/mmn_div.sv
// Shared restoring divider: off * 2^(FRAC_BITS+2) / span, one quotient bit per cycle.
// Depends on mmn_pkg.
`timescale 1ns / 1ps

module mmn_div
    import mmn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SPAN_W-1:0] span,
    input  logic [SPAN_W-1:0] off,
    output logic              done,
    output logic [QEXT_W-1:0] quo
);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QEXT_W-1:0] quo_reg;
    logic [SPAN_W-1:0] span_reg;

    logic [REM_W-1:0]  shifted;
    logic              ge;
    logic [REM_W-1:0]  rem_next;
    logic              last;

    // first step keeps the integer bit (off may equal span), later steps shift
    always_comb begin
        shifted  = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
        ge       = shifted >= {1'b0, span_reg};
        rem_next = ge ? shifted - {1'b0, span_reg} : shifted;
        last     = cnt_reg == CNT_W'(QEXT_W - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && run_reg && last;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, off};
            span_reg <= span;
            quo_reg  <= '0;
        end else if (run_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QEXT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### hw/rtl/mag_minmax_normalizer.sv
// Takes one beat at a time: per axis ST_UPD, then ST_DIV (skipped for a flat axis), then ST_STEP,
// then ST_OUT for the result; s_ready is high only in ST_IDLE.
// The shared divider gives one quotient bit per cycle and runs once per axis.
// A new beat is taken while the previous result waits on m_ready.
// Reset (aresetn low, synchronous): min 32767 / max -32768 per axis, no result pending.
// Depends on mmn_pkg and mmn_div.
`timescale 1ns / 1ps

module mag_minmax_normalizer
    import mmn_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_mag_x,
    input  logic signed [DATA_W-1:0] s_mag_y,
    input  logic signed [DATA_W-1:0] s_mag_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_norm_x,
    output logic signed [DATA_W-1:0] m_norm_y,
    output logic signed [DATA_W-1:0] m_norm_z,
    output logic [AXES-1:0]          m_flat_axes
);

    mmn_state_t state_reg, state_next;

    logic [AXIS_W-1:0]        axis_reg;
    logic signed [DATA_W-1:0] samp_reg [AXES];
    logic signed [DATA_W-1:0] lo_reg   [AXES];
    logic signed [DATA_W-1:0] hi_reg   [AXES];
    logic signed [DATA_W-1:0] res_reg  [AXES];
    logic [AXES-1:0]          flat_reg;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_norm_x_reg, m_norm_y_reg, m_norm_z_reg;
    logic [AXES-1:0]          m_flat_reg;

    logic signed [DATA_W-1:0] s_cur, lo_new, hi_new;
    logic [SPAN_W-1:0]        span_w, off_w;
    logic                     flat_w;
    logic                     last_axis;

    logic in_acc, upd_en, div_start, div_take, axis_inc, out_load;

    logic              div_done;
    logic [QEXT_W-1:0] div_quo;

    // per-axis update, one axis per ST_UPD cycle
    always_comb begin
        s_cur     = samp_reg[axis_reg];
        lo_new    = (s_cur < lo_reg[axis_reg]) ? s_cur : lo_reg[axis_reg];
        hi_new    = (s_cur > hi_reg[axis_reg]) ? s_cur : hi_reg[axis_reg];
        span_w    = {hi_new[DATA_W-1], hi_new} - {lo_new[DATA_W-1], lo_new};
        off_w     = {s_cur[DATA_W-1], s_cur} - {lo_new[DATA_W-1], lo_new};
        flat_w    = span_w == '0;
        last_axis = axis_reg == AXIS_W'(AXES - 1);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid)  state_next = ST_UPD;
            ST_UPD:  state_next = flat_w ? ST_STEP : ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_STEP;
            ST_STEP: state_next = last_axis ? ST_OUT : ST_UPD;
            ST_OUT:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = state_reg == ST_IDLE;
        in_acc    = s_ready && s_valid;
        upd_en    = state_reg == ST_UPD;
        div_start = upd_en && !flat_w;
        div_take  = (state_reg == ST_DIV) && div_done;
        axis_inc  = (state_reg == ST_STEP) && !last_axis;
        out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    mmn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .span    (span_w),
        .off     (off_w),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                lo_reg[i] <= LO_INIT;
                hi_reg[i] <= HI_INIT;
            end
        end else begin
            state_reg <= state_next;
            if (in_acc) begin
                axis_reg <= '0;
            end else if (axis_inc) begin
                axis_reg <= axis_reg + AXIS_W'(1);
            end
            if (upd_en) begin
                lo_reg[axis_reg] <= lo_new;
                hi_reg[axis_reg] <= hi_new;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            samp_reg[0] <= s_mag_x;
            samp_reg[1] <= s_mag_y;
            samp_reg[2] <= s_mag_z;
        end
        if (upd_en && flat_w) begin
            res_reg[axis_reg]  <= '0;
            flat_reg[axis_reg] <= 1'b1;
        end
        if (div_take) begin
            res_reg[axis_reg]  <= round_sat(div_quo);
            flat_reg[axis_reg] <= 1'b0;
        end
        if (out_load) begin
            m_norm_x_reg <= res_reg[0];
            m_norm_y_reg <= res_reg[1];
            m_norm_z_reg <= res_reg[2];
            m_flat_reg   <= flat_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_norm_x    = m_norm_x_reg;
    assign m_norm_y    = m_norm_y_reg;
    assign m_norm_z    = m_norm_z_reg;
    assign m_flat_axes = m_flat_reg;

endmodule

### hw/rtl/mmn_checker.sv
// Port-level assertions for mag_minmax_normalizer, bound to the top level below.
// Depends on mmn_pkg and mag_minmax_normalizer_defines.svh.
`timescale 1ns / 1ps
`include "mag_minmax_normalizer_defines.svh"

module mmn_checker
    import mmn_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic signed [DATA_W-1:0] s_mag_x,
    input logic signed [DATA_W-1:0] s_mag_y,
    input logic signed [DATA_W-1:0] s_mag_z,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DATA_W-1:0] m_norm_x,
    input logic signed [DATA_W-1:0] m_norm_y,
    input logic signed [DATA_W-1:0] m_norm_z,
    input logic [AXES-1:0]          m_flat_axes
);

    `MMN_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "m_valid after reset")

    `MMN_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_norm_x) && $stable(m_norm_y) && $stable(m_norm_z) && $stable(m_flat_axes), "stalled result beat changed")

    `MMN_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "took a second beat while busy")

    `MMN_ASSERT(a_flat_zero, m_valid |-> (!m_flat_axes[0] || m_norm_x == '0) && (!m_flat_axes[1] || m_norm_y == '0) && (!m_flat_axes[2] || m_norm_z == '0), "flat axis with nonzero value")

    `MMN_ASSERT(a_range, m_valid |-> m_norm_x <= NORM_MAX && m_norm_x >= NORM_MIN && m_norm_y <= NORM_MAX && m_norm_y >= NORM_MIN && m_norm_z <= NORM_MAX && m_norm_z >= NORM_MIN, "normalized value out of range")

endmodule

bind mag_minmax_normalizer mmn_checker u_mmn_checker (.*);
